### rtl/core/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and the reciprocal table of the motion activity
// and sleep detector.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Field widths.
  localparam int ACTION_W   = 2;
  localparam int GYRO_W     = 16;
  localparam int ACCEL_W    = 16;
  localparam int DT_W       = 10;
  localparam int LEVEL_W    = 17;
  localparam int FRAC_W     = 8;
  localparam int ENERGY_W   = LEVEL_W + FRAC_W;
  localparam int TIME_W     = 22;
  localparam int DTC_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Tick handling.
  localparam int DT_MAX      = 250;
  localparam int DT_DIV      = 2000;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 34;
  localparam int RECIP_N     = 2 ** DTC_W;
  localparam logic [TIME_W-1:0] STILL_MAX = '1;

  // Register reset values.
  localparam logic [TIME_W-1:0]  DROWSY_RST = TIME_W'(30000);
  localparam logic [TIME_W-1:0]  SLEEP_RST  = TIME_W'(120000);
  localparam logic [LEVEL_W-1:0] CALM_RST   = LEVEL_W'(160);
  localparam logic [LEVEL_W-1:0] WAKE_RST   = LEVEL_W'(960);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_SLEEPY = 2'd2,
    ACT_WAKE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_AWAKE  = 2'd0,
    ST_DROWSY = 2'd1,
    ST_ASLEEP = 2'd2
  } activity_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_SLEEPY_EN  = 3'd1,
    REG_DROWSY_MS  = 3'd2,
    REG_SLEEP_MS   = 3'd3,
    REG_CALM_LEVEL = 3'd4,
    REG_WAKE_LEVEL = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                 enable;
    logic                 sleepy_enable;
    logic [TIME_W-1:0]    drowsy_after_ms;
    logic [TIME_W-1:0]    sleep_after_ms;
    logic [LEVEL_W-1:0]   calm_level;
    logic [LEVEL_W-1:0]   wake_level;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic [GYRO_W-1:0]         gyro_mag;
    logic signed [ACCEL_W-1:0] accel_dev;
    logic [DT_W-1:0]           dt_ms;
  } item_t;

  typedef struct packed {
    logic [1:0] activity;
    logic       shake_pulse;
    logic       drowsy_entered;
    logic       asleep_entered;
    logic       woke;
    logic       wake_flash;
  } result_t;

  // Rounded-up reciprocals of 2000 / dt, scaled by 2^36. For any energy
  // difference below 2^25 the product shifted right by 36 equals the exact
  // floor of difference * dt / 2000.
  typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_N];

  function automatic recip_tab_t make_recip();
    recip_tab_t tab;
    for (int i = 0; i < RECIP_N; i++) begin
      tab[i] = RECIP_W'(((64'(i) << RECIP_SHIFT) + 64'(DT_DIV - 1)) / 64'(DT_DIV));
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = make_recip();

endpackage

### rtl/core/msd_in_if.sv
// ----------------------------------------------------------------------------
// msd_in_if
// Input channel of the detector: one motion sample, tick or command per item.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [msd_pkg::ACTION_W-1:0]          action;
  logic [msd_pkg::GYRO_W-1:0]            gyro_mag;
  logic signed [msd_pkg::ACCEL_W-1:0]    accel_dev;
  logic [msd_pkg::DT_W-1:0]              dt_ms;

  modport source (output valid, action, gyro_mag, accel_dev, dt_ms, input ready);
  modport sink (input valid, action, gyro_mag, accel_dev, dt_ms, output ready);
endinterface

### rtl/core/msd_out_if.sv
// ----------------------------------------------------------------------------
// msd_out_if
// Result channel of the detector: activity state and event flags per item.
// ----------------------------------------------------------------------------
interface msd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] activity;
  logic       shake_pulse;
  logic       drowsy_entered;
  logic       asleep_entered;
  logic       woke;
  logic       wake_flash;

  modport source (output valid, activity, shake_pulse, drowsy_entered, asleep_entered,
                  woke, wake_flash, input ready);
  modport sink (input valid, activity, shake_pulse, drowsy_entered, asleep_entered,
                woke, wake_flash, output ready);
endinterface

### rtl/core/msd_cfg_regs.sv
// ----------------------------------------------------------------------------
// msd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module msd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]   wr_data,
  output msd_pkg::cfg_t                    cfg
);
  import msd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b1;
      cfg.sleepy_enable   <= 1'b1;
      cfg.drowsy_after_ms <= DROWSY_RST;
      cfg.sleep_after_ms  <= SLEEP_RST;
      cfg.calm_level      <= CALM_RST;
      cfg.wake_level      <= WAKE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENABLE:     cfg.enable          <= wr_data[0];
        REG_SLEEPY_EN:  cfg.sleepy_enable   <= wr_data[0];
        REG_DROWSY_MS:  cfg.drowsy_after_ms <= wr_data[TIME_W-1:0];
        REG_SLEEP_MS:   cfg.sleep_after_ms  <= wr_data[TIME_W-1:0];
        REG_CALM_LEVEL: cfg.calm_level      <= wr_data[LEVEL_W-1:0];
        REG_WAKE_LEVEL: cfg.wake_level      <= wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/msd_energy.sv
// ----------------------------------------------------------------------------
// msd_energy
// Smoothed energy update for one tick: moves the energy toward the instant
// level by difference * dt / 2000, truncated toward zero.
// ----------------------------------------------------------------------------
module msd_energy (
  input  logic [msd_pkg::LEVEL_W-1:0]   instant_level,
  input  logic [msd_pkg::ENERGY_W-1:0]  energy,
  input  logic [msd_pkg::DTC_W-1:0]     dt,
  output logic [msd_pkg::ENERGY_W-1:0]  energy_next
);
  import msd_pkg::*;

  localparam int PROD_W = ENERGY_W + RECIP_W;

  logic [ENERGY_W-1:0] target;
  logic                rising;
  logic [ENERGY_W-1:0] diff;
  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod;
  logic [ENERGY_W-1:0] step;

  assign target = {instant_level, {FRAC_W{1'b0}}};
  assign rising = target >= energy;
  assign diff   = rising ? (target - energy) : (energy - target);
  assign recip  = RECIP_TAB[dt];
  assign prod   = PROD_W'(diff) * PROD_W'(recip);
  // The step never exceeds the difference, so it fits the energy width.
  assign step   = ENERGY_W'(prod[PROD_W-1:RECIP_SHIFT]);

  assign energy_next = rising ? (energy + step) : (energy - step);

endmodule

### rtl/core/msd_core.sv
// ----------------------------------------------------------------------------
// msd_core
// Detector state and the per-item update: instant level, energy, spike
// detector, stillness timer and the awake/drowsy/asleep machine.
// ----------------------------------------------------------------------------
module msd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  msd_pkg::item_t    item,
  input  msd_pkg::cfg_t     cfg,
  output msd_pkg::result_t  result
);
  import msd_pkg::*;

  // State registers.
  logic [LEVEL_W-1:0]  instant_level;
  logic [ENERGY_W-1:0] energy;
  logic [TIME_W-1:0]   still_time;
  logic                spike_armed;
  activity_t           state;

  logic [LEVEL_W-1:0]  instant_level_next;
  logic [ENERGY_W-1:0] energy_next;
  logic [ENERGY_W-1:0] energy_tick;
  logic [TIME_W-1:0]   still_time_next;
  logic                spike_armed_next;
  activity_t           state_next;

  logic                active;
  logic                quiet_wake;
  activity_t           state_base;
  logic                is_tick;
  logic                tick_active;
  logic [DTC_W-1:0]    dtc;
  logic [ACCEL_W:0]    accel_mag;
  logic [ACCEL_W+4:0]  accel_scaled;
  logic                spike;
  logic                calm;
  logic [TIME_W:0]     still_sum;
  logic [TIME_W-1:0]   still_tick;
  logic                woke;

  assign active     = cfg.enable & cfg.sleepy_enable;
  assign quiet_wake = !active && (state != ST_AWAKE);
  assign state_base = quiet_wake ? ST_AWAKE : state;

  assign is_tick     = (item.action == ACT_TICK) && (item.dt_ms != '0);
  assign tick_active = is_tick && active;
  assign dtc = (item.dt_ms > DT_W'(DT_MAX)) ? DTC_W'(DT_MAX) : item.dt_ms[DTC_W-1:0];

  // Instant level from a sample: gyro plus 15/16 of the accel magnitude.
  assign accel_mag    = item.accel_dev[ACCEL_W-1] ? ((ACCEL_W+1)'(0) - (ACCEL_W+1)'(item.accel_dev))
                                                  : (ACCEL_W+1)'(item.accel_dev);
  assign accel_scaled = {accel_mag, 4'b0000} - (ACCEL_W+5)'(accel_mag);

  always_comb begin
    instant_level_next = instant_level;
    if (item.action == ACT_SAMPLE) begin
      instant_level_next = LEVEL_W'(item.gyro_mag) + LEVEL_W'(accel_scaled[ACCEL_W+4:4]);
    end
  end

  msd_energy u_energy (
    .instant_level (instant_level),
    .energy        (energy),
    .dt            (dtc),
    .energy_next   (energy_tick)
  );

  assign energy_next = is_tick ? energy_tick : energy;

  // Spike detector re-arms once the level falls below half the wake level.
  assign spike = instant_level > cfg.wake_level;

  always_comb begin
    spike_armed_next = spike_armed;
    if (is_tick) begin
      if (spike) begin
        spike_armed_next = 1'b0;
      end else if ({instant_level, 1'b0} < {1'b0, cfg.wake_level}) begin
        spike_armed_next = 1'b1;
      end
    end
  end

  // Stillness timer for a non-spike tick, saturating.
  assign calm       = energy_tick < {cfg.calm_level, {FRAC_W{1'b0}}};
  assign still_sum  = (TIME_W+1)'(still_time) + (TIME_W+1)'(dtc);
  assign still_tick = !calm ? '0 : (still_sum[TIME_W] ? STILL_MAX : still_sum[TIME_W-1:0]);

  // Next state of the activity machine.
  always_comb begin
    state_next = state_base;
    case (item.action)
      ACT_TICK: begin
        if (tick_active) begin
          if (spike) begin
            state_next = ST_AWAKE;
          end else begin
            case (state_base)
              ST_AWAKE: begin
                if (still_tick >= cfg.drowsy_after_ms) state_next = ST_DROWSY;
              end
              ST_DROWSY: begin
                if (still_tick >= cfg.sleep_after_ms) begin
                  state_next = ST_ASLEEP;
                end else if (still_tick == '0) begin
                  state_next = ST_AWAKE;
                end
              end
              default: state_next = state_base;
            endcase
          end
        end
      end
      ACT_SLEEPY: state_next = ST_ASLEEP;
      ACT_WAKE:   state_next = ST_AWAKE;
      default:    state_next = state_base;
    endcase
  end

  // Event flags of the machine.
  always_comb begin
    woke                  = quiet_wake || (state_base != ST_AWAKE && state_next == ST_AWAKE);
    result.activity       = state_next;
    result.shake_pulse    = is_tick && spike && spike_armed;
    result.drowsy_entered = (state_base == ST_AWAKE) && (state_next != ST_AWAKE);
    result.asleep_entered = (state_base != ST_ASLEEP) && (state_next == ST_ASLEEP);
    result.woke           = woke;
    result.wake_flash     = (state_base == ST_ASLEEP) && (state_next == ST_AWAKE);
  end

  always_comb begin
    still_time_next = still_time;
    if (woke) begin
      still_time_next = '0;
    end else if (tick_active) begin
      still_time_next = spike ? '0 : still_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      instant_level <= '0;
      energy        <= '0;
      still_time    <= '0;
      spike_armed   <= 1'b1;
      state         <= ST_AWAKE;
    end else if (fire) begin
      instant_level <= instant_level_next;
      energy        <= energy_next;
      still_time    <= still_time_next;
      spike_armed   <= spike_armed_next;
      state         <= state_next;
    end
  end

endmodule

### rtl/core/motion_activity_sleep_detector_unit.sv
// Path: an accepted item passes the input register, then the result register,
// which takes its outcome only when empty or being drained. Throughput: one
// item per cycle while the result channel is not stalled, set by the single
// combinational update pass between the two registers (one 25x34 multiply).
// Reset: synchronous, active high; clears both channel registers, loads the
// configuration defaults and returns the detector to awake, armed, zero energy.
// ----------------------------------------------------------------------------
// motion_activity_sleep_detector_unit
// Top level of the motion activity and sleep detector. Motion samples set
// an instant level; ticks smooth it into an energy, run a re-arming shake
// detector and a stillness timer, and move an awake/drowsy/asleep machine.
// ----------------------------------------------------------------------------
module motion_activity_sleep_detector_unit (
  input  logic                             clk,
  input  logic                             rst,
  msd_in_if.sink                           sensor,
  msd_out_if.source                        status,
  input  logic                             wr_en,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]   wr_data
);
  import msd_pkg::*;

  // The input register holds one accepted item until the result register
  // can take its outcome. The item is processed in the cycle it leaves the
  // input register; the detector state and the result register update at
  // that same edge, so a new item may arrive every cycle unless the result register is stalled.
  logic    held_valid;
  item_t   held;
  logic    out_valid;
  result_t out_data;
  result_t result_next;
  cfg_t    cfg;
  logic    fire;

  // An item moves on when the result register is empty or being drained.
  assign fire         = held_valid && (!out_valid || status.ready);
  assign sensor.ready = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sensor.valid && sensor.ready) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      held.action    <= sensor.action;
      held.gyro_mag  <= sensor.gyro_mag;
      held.accel_dev <= sensor.accel_dev;
      held.dt_ms     <= sensor.dt_ms;
    end
  end

  msd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  msd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held),
    .cfg    (cfg),
    .result (result_next)
  );

  // Result register: one result item per input item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result_next;
    end
  end

  assign status.valid          = out_valid;
  assign status.activity       = out_data.activity;
  assign status.shake_pulse    = out_data.shake_pulse;
  assign status.drowsy_entered = out_data.drowsy_entered;
  assign status.asleep_entered = out_data.asleep_entered;
  assign status.woke           = out_data.woke;
  assign status.wake_flash     = out_data.wake_flash;

endmodule
